FILE: sv/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg: shared types and constants of the move-to-front coder
// Holds the list size, the symbol type, the item structs of both channels
// and the control struct that the core broadcasts to every list cell.
// ----------------------------------------------------------------------------
package mtf_pkg;

   localparam int AlphabetSize = 256;
   localparam int SymbolWidth  = 8;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic DirEncode = 1'b0;
   localparam logic DirDecode = 1'b1;

   localparam logic RegDirection = 1'b0;

   typedef logic [SymbolWidth-1:0] symbol_type;

   typedef struct packed {
      symbol_type in_value;
      logic       last_of_block;
   } req_item_type;

   typedef struct packed {
      symbol_type out_value;
      logic       out_last;
   } rsp_item_type;

   typedef struct packed {
      logic       match_en;
      logic       shift_en;
      logic       restore;
      logic       dir;
      logic       found;
      symbol_type key;
      symbol_type pos;
   } cell_ctl_type;

endpackage

FILE: sv/mtf_cell.sv
// ----------------------------------------------------------------------------
// mtf_cell: one entry of the move-to-front list
// Compares its entry or its position with the key; on a move takes the entry
// ahead of it when at or ahead of the hit, or its own index at a block's end.
// ----------------------------------------------------------------------------
module mtf_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  mtf_pkg::cell_ctl_type ctl,
   input  mtf_pkg::symbol_type  cell_index,
   input  mtf_pkg::symbol_type  prev_value,
   output mtf_pkg::symbol_type  value,
   output logic                 hit
);

   mtf_pkg::symbol_type value_ff;
   mtf_pkg::symbol_type value_in;
   logic                hit_ff;
   logic                hit_in;

   always_comb begin
      if (ctl.dir == mtf_pkg::DirDecode) begin
         hit_in = (ctl.key == cell_index);
      end else begin
         hit_in = (ctl.key == value_ff);
      end
   end

   always_comb begin
      value_in = value_ff;
      if (ctl.shift_en) begin
         if (ctl.restore) begin
            value_in = cell_index;
         end else if (ctl.found && (cell_index <= ctl.pos)) begin
            value_in = prev_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= cell_index;
         hit_ff   <= 1'b0;
      end else begin
         value_ff <= value_in;
         if (ctl.match_en) begin
            hit_ff <= hit_in;
         end
      end
   end

   assign value = value_ff;
   assign hit   = hit_ff;

endmodule

FILE: sv/move_to_front_coder_core.sv
// ----------------------------------------------------------------------------
// move_to_front_coder_core: move-to-front coder over a 256-entry byte list
//
//   Channel   Ports                     Direction  Moves
//   req       req_valid/req_stall/req_item   in     byte or list position
//   rsp       rsp_valid/rsp_stall/rsp_item   out    list position or byte
//   csr       psel/penable/pwrite/paddr/...  in     direction register
//
// An item passes through StMatch, StReduce and StShift: the cells compare in
// StMatch, the hit is reduced to a position and a byte in StReduce, and the
// list moves and the result is registered in StShift. The next item is taken
// in StShift. Reset restores identity order at once, with no clearing pass.
// A stalled result holds StShift until the output register frees.
// ----------------------------------------------------------------------------
module move_to_front_coder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mtf_pkg::req_item_type               req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mtf_pkg::rsp_item_type               rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mtf_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [mtf_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [mtf_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StMatch  = 2'd1;
   localparam logic [1:0] StReduce = 2'd2;
   localparam logic [1:0] StShift  = 2'd3;

   logic [1:0]                    state_ff;
   logic [1:0]                    state_in;
   logic                          direction_ff;
   mtf_pkg::symbol_type           key_ff;
   logic                          last_ff;
   mtf_pkg::symbol_type           pos_ff;
   mtf_pkg::symbol_type           sym_ff;
   logic                          found_ff;
   mtf_pkg::symbol_type           pos_or;
   mtf_pkg::symbol_type           sym_or;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   mtf_pkg::rsp_item_type         rsp_item_ff;
   mtf_pkg::rsp_item_type         rsp_item_in;
   logic                          out_free;
   logic                          done;
   logic                          accept;
   logic                          reg_sel;
   mtf_pkg::cell_ctl_type         ctl;
   logic [mtf_pkg::AlphabetSize-1:0] hit;
   mtf_pkg::symbol_type           list_value [mtf_pkg::AlphabetSize];

   // Register access.
   assign pready  = 1'b1;
   assign reg_sel = (paddr[mtf_pkg::CsrAddrWidth-1] == mtf_pkg::RegDirection);
   assign prdata  = reg_sel ? {{(mtf_pkg::CsrDataWidth-1){1'b0}}, direction_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= mtf_pkg::DirEncode;
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         direction_ff <= pwdata[0];
      end
   end

   // Sequencing.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign done      = (state_ff == StShift) && out_free;
   assign req_stall = !((state_ff == StIdle) || done);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StMatch;
            end
         end
         StMatch: begin
            state_in = StReduce;
         end
         StReduce: begin
            state_in = StShift;
         end
         StShift: begin
            if (done) begin
               state_in = accept ? StMatch : StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff  <= req_item.in_value;
         last_ff <= req_item.last_of_block;
      end
   end

   // List cells.
   assign ctl.match_en = (state_ff == StMatch);
   assign ctl.shift_en = done;
   assign ctl.restore  = last_ff;
   assign ctl.dir      = direction_ff;
   assign ctl.found    = found_ff;
   assign ctl.key      = key_ff;
   assign ctl.pos      = pos_ff;

   for (genvar g = 0; g < mtf_pkg::AlphabetSize; g++) begin : g_cell
      mtf_pkg::symbol_type prev;
      if (g == 0) begin : g_front
         assign prev = sym_ff;
      end else begin : g_rest
         assign prev = list_value[g-1];
      end
      mtf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cell_index (mtf_pkg::symbol_type'(g)),
         .prev_value (prev),
         .value      (list_value[g]),
         .hit        (hit[g])
      );
   end

   // At most one cell hits, so the position and byte are plain OR trees.
   always_comb begin
      pos_or = '0;
      sym_or = '0;
      for (int i = 0; i < mtf_pkg::AlphabetSize; i++) begin
         pos_or = pos_or | (hit[i] ? mtf_pkg::symbol_type'(i) : '0);
         sym_or = sym_or | (hit[i] ? list_value[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == StReduce) begin
         pos_ff   <= pos_or;
         sym_ff   <= sym_or;
         found_ff <= |hit;
      end
   end

   // Output register.
   always_comb begin
      rsp_item_in.out_last = last_ff;
      if (!found_ff) begin
         rsp_item_in.out_value = key_ff;
      end else if (direction_ff == mtf_pkg::DirDecode) begin
         rsp_item_in.out_value = sym_ff;
      end else begin
         rsp_item_in.out_value = pos_ff;
      end
   end

   assign rsp_valid_in = done ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts_match: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == StMatch))
      else $error("accepted item did not start a match cycle");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == StMatch) || (state_ff == StReduce)) |-> req_stall)
      else $error("input taken while an item is in flight");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StReduce) |-> $onehot0(hit))
      else $error("more than one list cell matched");

   a_result_from_shift: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == StShift))
      else $error("result appeared outside the move cycle");
`endif

endmodule

FILE: dv/move_to_front_coder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// move_to_front_coder_core_test: self-checking bench of the move-to-front coder
// A short table of directed items and register writes runs first, followed
// by random phases in both directions. Every accepted item is run through a
// local move-to-front list, and each result is compared against the oldest
// pending code. Both channels idle at random. One phase holds the result
// side off long enough to back the core up onto its input.
// ----------------------------------------------------------------------------
module move_to_front_coder_core_test;

   localparam int ResetCycles   = 12;
   localparam int DrainCycles   = 6;
   localparam int TailCycles    = 12;
   localparam int HoldOffCycles = 150;
   localparam int BurstItems    = 40;
   localparam int WatchdogLimit = 2000;
   localparam int RandomPhases  = 6;
   localparam int PhaseItems    = 90;
   localparam int MaxReports    = 10;

   localparam logic [mtf_pkg::CsrAddrWidth-1:0] DirectionAddr =
      mtf_pkg::CsrAddrWidth'(4 * mtf_pkg::RegDirection);
   localparam logic [mtf_pkg::CsrAddrWidth-1:0] SpareAddr = mtf_pkg::CsrAddrWidth'(4);

   typedef enum logic {RowItem, RowWrite} row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      logic [mtf_pkg::CsrAddrWidth-1:0]     addr;
      logic [mtf_pkg::CsrDataWidth-1:0]     data;
      mtf_pkg::req_item_type                item;
      logic                                 typed;
      mtf_pkg::rsp_item_type                want;
   } plan_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   mtf_pkg::req_item_type            req_item;
   logic                             rsp_valid;
   logic                             rsp_stall;
   mtf_pkg::rsp_item_type            rsp_item;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [mtf_pkg::CsrAddrWidth-1:0] paddr;
   logic [mtf_pkg::CsrDataWidth-1:0] pwdata;
   logic [mtf_pkg::CsrDataWidth-1:0] prdata;
   logic                             pready;

   mtf_pkg::symbol_type     symbol_order [mtf_pkg::AlphabetSize];
   logic                    coder_dir;
   mtf_pkg::rsp_item_type   pending_codes [$];
   mtf_pkg::symbol_type     recent_syms [8];
   plan_row_type            plan [$];
   int                      mismatch_count;
   int                      idle_cycles;
   logic                    quiet;
   logic                    burst;
   logic                    hold_off_req;
   logic                    holding;

   move_to_front_coder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void restore_identity();
      int i;
      for (i = 0; i < mtf_pkg::AlphabetSize; i++) symbol_order[i] = mtf_pkg::symbol_type'(i);
   endfunction

   function automatic mtf_pkg::rsp_item_type mtf_code_symbol(input mtf_pkg::req_item_type it);
      mtf_pkg::rsp_item_type code;
      mtf_pkg::symbol_type   sym;
      int                    pos;
      int                    i;
      logic                  found;
      pos = 0;
      found = 1'b0;
      code.out_last = it.last_of_block;
      if (coder_dir == mtf_pkg::DirEncode) begin
         for (i = 0; i < mtf_pkg::AlphabetSize; i++) begin
            if (!found && symbol_order[i] == it.in_value) begin
               pos = i;
               found = 1'b1;
            end
         end
         code.out_value = mtf_pkg::symbol_type'(pos);
      end else begin
         pos = int'(it.in_value);
         code.out_value = symbol_order[pos];
      end
      sym = symbol_order[pos];
      for (i = pos; i > 0; i--) symbol_order[i] = symbol_order[i-1];
      symbol_order[0] = sym;
      if (it.last_of_block) restore_identity();
      return code;
   endfunction

   function automatic void note_failure(input string text);
      mismatch_count++;
      if (mismatch_count <= MaxReports) $display("mismatch at %0t: %s", $realtime, text);
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic mtf_pkg::req_item_type random_item(input logic dir);
      mtf_pkg::req_item_type it;
      int                    r;
      r = $urandom_range(0, 99);
      if (dir == mtf_pkg::DirEncode) begin
         if (r < 30) it.in_value = recent_syms[$urandom_range(0, 7)];
         else if (r < 60) it.in_value = mtf_pkg::symbol_type'($urandom());
         else if (r < 75) it.in_value = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         else it.in_value = mtf_pkg::symbol_type'($urandom_range(0, 15));
      end else begin
         if (r < 40) it.in_value = mtf_pkg::symbol_type'($urandom_range(0, 3));
         else if (r < 70) it.in_value = mtf_pkg::symbol_type'($urandom());
         else if (r < 80) it.in_value = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         else it.in_value = mtf_pkg::symbol_type'($urandom_range(0, 31));
      end
      it.last_of_block = ($urandom_range(0, 24) == 0);
      return it;
   endfunction

   function automatic plan_row_type item_row(input mtf_pkg::symbol_type value,
                                             input logic last);
      plan_row_type row;
      row = '0;
      row.kind = RowItem;
      row.item.in_value = value;
      row.item.last_of_block = last;
      return row;
   endfunction

   function automatic plan_row_type typed_row(input mtf_pkg::symbol_type value,
                                              input logic last,
                                              input mtf_pkg::symbol_type want_value);
      plan_row_type row;
      row = item_row(value, last);
      row.typed = 1'b1;
      row.want.out_value = want_value;
      row.want.out_last = last;
      return row;
   endfunction

   function automatic plan_row_type write_row(input logic [mtf_pkg::CsrAddrWidth-1:0] addr,
                                              input logic [mtf_pkg::CsrDataWidth-1:0] data);
      plan_row_type row;
      row = '0;
      row.kind = RowWrite;
      row.addr = addr;
      row.data = data;
      return row;
   endfunction

   task automatic send_item(input mtf_pkg::req_item_type it, input logic typed,
                            input mtf_pkg::rsp_item_type want);
      mtf_pkg::rsp_item_type code;
      int                    i;
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      code = mtf_code_symbol(it);
      pending_codes.push_back(typed ? want : code);
      for (i = 7; i > 0; i--) recent_syms[i] = recent_syms[i-1];
      recent_syms[0] = it.in_value;
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [mtf_pkg::CsrAddrWidth-1:0] addr,
                            input logic [mtf_pkg::CsrDataWidth-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == DirectionAddr) coder_dir = data[0];
      @(posedge clock);
   endtask

   task automatic csr_readback();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= DirectionAddr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== mtf_pkg::CsrDataWidth'(coder_dir))
         note_failure($sformatf("direction readback expected %0h, got %0h",
                                coder_dir, prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      rsp_stall <= 1'b0;
      holding = 1'b0;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            holding = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            holding = 1'b0;
         end else if (quiet || $urandom_range(0, 99) < 55) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (gap_length() + 1) @(posedge clock);
         end
      end
   end

   initial begin
      mtf_pkg::rsp_item_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_codes.size() == 0) begin
               note_failure($sformatf("result %0d/%0b with nothing pending",
                                      rsp_item.out_value, rsp_item.out_last));
            end else begin
               want = pending_codes.pop_front();
               if (rsp_item.out_value !== want.out_value)
                  note_failure($sformatf("out_value expected %0d, got %0d",
                                         want.out_value, rsp_item.out_value));
               if (rsp_item.out_last !== want.out_last)
                  note_failure($sformatf("out_last expected %0b, got %0b",
                                         want.out_last, rsp_item.out_last));
            end
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("** move_to_front_coder_core: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      mtf_pkg::req_item_type it;
      logic                  dir;
      int                    p;
      int                    n;
      int                    i;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      mismatch_count = 0;
      quiet = 1'b0;
      burst = 1'b0;
      hold_off_req = 1'b0;
      coder_dir = mtf_pkg::DirEncode;
      restore_identity();
      for (i = 0; i < 8; i++) recent_syms[i] = mtf_pkg::symbol_type'(i);

      plan.push_back(typed_row(8'd0,   1'b0, 8'd0));
      plan.push_back(typed_row(8'd255, 1'b0, 8'd255));
      plan.push_back(typed_row(8'd255, 1'b0, 8'd0));
      plan.push_back(item_row(8'd0,    1'b0));
      plan.push_back(item_row(8'd128,  1'b1));
      plan.push_back(typed_row(8'd200, 1'b0, 8'd200));
      plan.push_back(typed_row(8'd200, 1'b1, 8'd0));
      plan.push_back(typed_row(8'd7,   1'b0, 8'd7));
      plan.push_back(write_row(DirectionAddr, 32'h0000_0001));
      plan.push_back(item_row(8'd0,    1'b0));
      plan.push_back(item_row(8'd255,  1'b0));
      plan.push_back(item_row(8'd255,  1'b1));
      plan.push_back(typed_row(8'd0,   1'b0, 8'd0));
      plan.push_back(typed_row(8'd255, 1'b0, 8'd255));
      plan.push_back(item_row(8'd1,    1'b0));
      plan.push_back(item_row(8'd128,  1'b1));
      plan.push_back(write_row(SpareAddr, 32'h0000_0000));
      plan.push_back(typed_row(8'd42,  1'b0, 8'd42));
      plan.push_back(write_row(DirectionAddr, 32'hFFFF_FFFE));
      plan.push_back(item_row(8'd42,   1'b0));
      plan.push_back(item_row(8'd1,    1'b1));
      plan.push_back(typed_row(8'd128, 1'b1, 8'd128));
      plan.push_back(write_row(DirectionAddr, 32'hFFFF_FFFF));
      plan.push_back(item_row(8'd128,  1'b0));
      plan.push_back(item_row(8'd127,  1'b1));

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == RowWrite) begin
            drain_block();
            csr_write(plan[r].addr, plan[r].data);
            csr_readback();
         end else begin
            send_item(plan[r].item, plan[r].typed, plan[r].want);
            idle_gap(gap_length());
         end
      end

      for (p = 0; p < RandomPhases; p++) begin
         drain_block();
         quiet = (p == 2);
         dir = (p % 2 == 1) ? mtf_pkg::DirDecode : mtf_pkg::DirEncode;
         if (p == 5) begin
            csr_write(SpareAddr, $urandom());
            csr_readback();
         end
         csr_write(DirectionAddr,
                   ($urandom() & 32'hFFFF_FFFE) | mtf_pkg::CsrDataWidth'(dir));
         csr_readback();
         if (p == 4) begin
            hold_off_req = 1'b1;
            wait (holding);
            burst = 1'b1;
         end
         for (n = 0; n < PhaseItems; n++) begin
            if (n == BurstItems) burst = 1'b0;
            it = random_item(coder_dir);
            send_item(it, 1'b0, '0);
            if (!burst) idle_gap(gap_length());
         end
         quiet = 1'b0;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_codes.size() == 0) begin
         $display("** move_to_front_coder_core: PASSED **");
      end else begin
         $display("** move_to_front_coder_core: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/mtf_pkg.sv
sv/mtf_cell.sv
sv/move_to_front_coder_core.sv
dv/move_to_front_coder_core_test.sv
